// ===== hdl/gscl_pkg.sv =====
// Shared types and constants for the gain, saturation and level meter block.
package gscl_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int GAIN_W    = 16;
   localparam int LEN_W     = 12;
   localparam int SUM_W     = 27;
   localparam int LEVEL_W   = 10;
   localparam int FRAC_BITS = 12;
   localparam int MAG_IN_W  = SAMPLE_W + 1;
   localparam int PROD_W    = MAG_IN_W + GAIN_W;
   localparam int MAG_W     = PROD_W - FRAC_BITS;

   // level divider: quotient bits, divisor 4*n, partial remainder
   localparam int DIV_STEPS = LEVEL_W;
   localparam int DIV_W     = LEN_W + 2;
   localparam int REM_W     = DIV_W + DIV_STEPS;
   localparam int DS_W      = DIV_W + DIV_STEPS - 1;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHUNK_LEN = 2'd1;

   localparam logic [GAIN_W-1:0]  GAIN_RESET      = 16'd4096;
   localparam logic [LEN_W-1:0]   CHUNK_LEN_RESET = 12'd1920;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX       = 10'd1000;

   localparam logic [SAMPLE_W-1:0] POS_LIMIT = 16'h7fff;
   localparam logic [SAMPLE_W-1:0] NEG_LIMIT = 16'h8000;

   localparam int MAX_CHUNK_DEFAULT   = 4095;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_in;
      logic                       stream_end;
   } gscl_req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic                       level_valid;
      logic [LEVEL_W-1:0]         level_milli;
      logic                       stream_done;
   } gscl_rsp_type;

   // one scaled sample on its way from the front end to the back end
   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_out;
      logic                last;
      logic                close;
      logic [SUM_W-1:0]    sum;
      logic [LEN_W-1:0]    count;
   } gscl_entry_type;

endpackage

// ===== hdl/gscl_front.sv =====
// Front end: config registers, gain multiply, saturation and chunk accumulation.
module gscl_front import gscl_pkg::*; #(
   parameter int MAX_CHUNK = MAX_CHUNK_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  gscl_req_type           req_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   q_push,
   input  logic                   q_full,
   output gscl_entry_type         q_entry
);

   logic [GAIN_W-1:0] gain_ff;
   logic [LEN_W-1:0]  chunk_len_ff;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_neg_ff;
   logic              s1_last_ff;
   logic [MAG_W-1:0]  s1_mag_ff;

   logic [LEN_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;

   logic                req_accept;
   logic [SAMPLE_W-1:0] raw;
   logic [MAG_IN_W-1:0] mag_in;
   logic [PROD_W-1:0]   product;
   logic [SAMPLE_W-1:0] abs_val;
   logic [LEN_W-1:0]    len_nz;
   logic [LEN_W-1:0]    eff_len;
   logic [LEN_W-1:0]    count_next;
   logic [SUM_W-1:0]    sum_next;
   logic                close;

   assign req_full   = s1_valid_ff && q_full;
   assign req_accept = req_push && !req_full;
   assign q_push     = s1_valid_ff && !q_full;

   // magnitude times gain, Q12 fraction dropped (truncation toward zero)
   assign raw     = req_data.sample_in;
   assign mag_in  = raw[SAMPLE_W-1] ? (MAG_IN_W'(1) << SAMPLE_W) - {1'b0, raw} : {1'b0, raw};
   assign product = PROD_W'(mag_in) * PROD_W'(gain_ff);

   always_comb begin
      if (s1_neg_ff) begin
         abs_val = (s1_mag_ff > MAG_W'(NEG_LIMIT)) ? NEG_LIMIT : s1_mag_ff[SAMPLE_W-1:0];
      end else begin
         abs_val = (s1_mag_ff > MAG_W'(POS_LIMIT)) ? POS_LIMIT : s1_mag_ff[SAMPLE_W-1:0];
      end
   end

   always_comb begin
      len_nz  = (chunk_len_ff == '0) ? LEN_W'(1) : chunk_len_ff;
      eff_len = (32'(len_nz) > 32'(MAX_CHUNK)) ? LEN_W'(MAX_CHUNK) : len_nz;
   end

   assign count_next = count_ff + LEN_W'(1);
   assign sum_next   = sum_ff + SUM_W'(abs_val);
   assign close      = s1_last_ff || (count_next >= eff_len);

   always_comb begin
      q_entry.sample_out = s1_neg_ff ? SAMPLE_W'(0) - abs_val : abs_val;
      q_entry.last       = s1_last_ff;
      q_entry.close      = close;
      q_entry.sum        = sum_next;
      q_entry.count      = count_next;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (q_push) begin
         s1_valid_in = 1'b0;
      end
      count_in = count_ff;
      sum_in   = sum_ff;
      if (q_push) begin
         count_in = close ? '0 : count_next;
         sum_in   = close ? '0 : sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_neg_ff  <= raw[SAMPLE_W-1];
         s1_last_ff <= req_data.stream_end;
         s1_mag_ff  <= product[PROD_W-1:FRAC_BITS];
      end
      if (reset) begin
         gain_ff      <= GAIN_RESET;
         chunk_len_ff <= CHUNK_LEN_RESET;
         s1_valid_ff  <= 1'b0;
         count_ff     <= '0;
         sum_ff       <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_GAIN:      gain_ff      <= csr_data[GAIN_W-1:0];
               CSR_CHUNK_LEN: chunk_len_ff <= csr_data[LEN_W-1:0];
               default: ;
            endcase
         end
         s1_valid_ff <= s1_valid_in;
         count_ff    <= count_in;
         sum_ff      <= sum_in;
      end
   end

endmodule

// ===== hdl/gscl_queue.sv =====
// Small flop-based queue between the front end and the level divider.
module gscl_queue import gscl_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   output logic           full,
   input  gscl_entry_type push_entry,
   input  logic           pop,
   output logic           empty,
   output gscl_entry_type pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   gscl_entry_type   mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/gscl_back.sv =====
// Back end: level divider for closing samples and the result output register.
module gscl_back import gscl_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           q_empty,
   input  gscl_entry_type q_entry,
   output logic           q_pop,
   output logic           rsp_empty,
   input  logic           rsp_pop,
   output gscl_rsp_type   rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

   state_type           state_ff, state_in;
   logic                out_valid_ff, out_valid_in;
   gscl_rsp_type        out_data_ff, out_data_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                last_ff, last_in;
   logic                sat_ff, sat_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [DS_W-1:0]     div_ff, div_in;
   logic [LEVEL_W-1:0]  quo_ff, quo_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   logic               out_free;
   logic [DIV_W-1:0]   divisor;
   logic [LEVEL_W-1:0] level;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;
   assign divisor   = {q_entry.count, 2'b00};
   assign level     = (sat_ff || quo_ff > LEVEL_MAX) ? LEVEL_MAX : quo_ff;

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_data_in  = out_data_ff;
      sample_in    = sample_ff;
      last_in      = last_ff;
      sat_in       = sat_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               if (q_entry.close) begin
                  // quotient >= 1024 saturates; otherwise 10 restoring steps suffice
                  q_pop     = 1'b1;
                  sample_in = q_entry.sample_out;
                  last_in   = q_entry.last;
                  sat_in    = q_entry.sum >= SUM_W'({divisor, {DIV_STEPS{1'b0}}});
                  rem_in    = q_entry.sum[REM_W-1:0];
                  div_in    = {divisor, {(DIV_STEPS-1){1'b0}}};
                  quo_in    = '0;
                  step_in   = '0;
                  state_in  = ST_DIVIDE;
               end else if (out_free) begin
                  q_pop                   = 1'b1;
                  out_valid_in            = 1'b1;
                  out_data_in.sample_out  = q_entry.sample_out;
                  out_data_in.level_valid = 1'b0;
                  out_data_in.level_milli = '0;
                  out_data_in.stream_done = q_entry.last;
               end
            end
         end
         ST_DIVIDE: begin
            if (rem_ff >= REM_W'(div_ff)) begin
               rem_in = rem_ff - REM_W'(div_ff);
               quo_in = {quo_ff[LEVEL_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_ff[LEVEL_W-2:0], 1'b0};
            end
            div_in  = div_ff >> 1;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in            = 1'b1;
               out_data_in.sample_out  = sample_ff;
               out_data_in.level_valid = 1'b1;
               out_data_in.level_milli = level;
               out_data_in.stream_done = last_ff;
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      sample_ff   <= sample_in;
      last_ff     <= last_in;
      sat_ff      <= sat_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== hdl/gain_saturate_chunk_level_meter_top.sv =====
// Top level of the digital gain, saturation and chunk level meter.
// Scales 16-bit samples by a Q4.12 gain (truncated toward zero, saturated to
// int16) and returns one result per sample. The sample that closes a chunk
// (full length reached or stream_end set) also carries the chunk level
// min(sum|x| / (4*n), 1000). The front end takes one sample per clock, while
// the queue has room, through a multiplier stage and the accumulator; a short
// queue decouples it from the back end, which passes ordinary samples at one
// per clock while its output register is free or being popped. A closing
// sample is taken, run through the bit-serial level divider at one quotient
// bit per cycle, and then loaded into the output register once that is free.
// Results are held in an output register, so the block keeps accepting while
// a result waits to be popped, until the front stage and the queue are full.
module gain_saturate_chunk_level_meter_top import gscl_pkg::*; #(
   parameter int MAX_CHUNK   = MAX_CHUNK_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  gscl_req_type           req_data,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output gscl_rsp_type           rsp_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic           q_push, q_full, q_pop, q_empty;
   gscl_entry_type q_push_entry, q_pop_entry;

   gscl_front #(
      .MAX_CHUNK (MAX_CHUNK)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_push    (q_push),
      .q_full    (q_full),
      .q_entry   (q_push_entry)
   );

   gscl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .full       (q_full),
      .push_entry (q_push_entry),
      .pop        (q_pop),
      .empty      (q_empty),
      .pop_entry  (q_pop_entry)
   );

   gscl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_entry   (q_pop_entry),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
